>>> rtl/peg_pkg.sv
// ----------------------------------------------------------------------------
// peg_pkg: shared types and constants of the polynomial gradient block
// Holds the queue entry type, the sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package peg_pkg;
  localparam int unsigned DataW      = 32;
  localparam int unsigned SumW       = 48;
  localparam int unsigned CntW       = 3;
  localparam int unsigned MaxCoeffsD = 7;
  localparam int unsigned FracBitsD  = 16;
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [CntW-1:0] RegCount = 3'd0;
  localparam logic [CntW-1:0] RegCoef0 = 3'd1;

  // result kinds
  localparam logic KindPoint = 1'b0;
  localparam logic KindCoef  = 1'b1;

  // sequencer states of the back part
  typedef enum logic [2:0] {
    S_IDLE, S_HMUL, S_HADD, S_GMUL, S_PMUL, S_TERM, S_EMIT
  } state_e;

  // item handed from the front to the back through the queue
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] g;
    logic                    last;
    logic [CntW-1:0]         n;
  } job_t;
endpackage
`default_nettype wire

>>> rtl/peg_front.sv
// ----------------------------------------------------------------------------
// peg_front: accepts input items and queues them with the active count
// Holds the configuration registers and a small FIFO toward the back.
// ----------------------------------------------------------------------------
`default_nettype none
module peg_front import peg_pkg::*; #(
  parameter int unsigned MAX_COEFFS = MaxCoeffsD
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CntW-1:0]   cfg_index_i,
  input  wire logic [DataW-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [DataW-1:0]  point_x_i,
  input  wire logic [DataW-1:0]  out_grad_i,
  input  wire logic              final_point_i,
  output logic [MAX_COEFFS*DataW-1:0] coefs_o,
  output logic                   job_valid_o,
  output job_t                   job_o,
  input  wire logic              job_take_i
);
  logic [CntW-1:0] count_q;
  logic [DataW-1:0] coef_q [MAX_COEFFS];
  job_t fifo_q [QueueDepth];
  logic rd_q, wr_q;
  logic [1:0] fill_q;
  logic [CntW-1:0] n_act;
  logic push;

  // clamp the count into 1..MAX_COEFFS
  always_comb begin
    n_act = count_q;
    if (count_q == '0) n_act = CntW'(1);
    if (32'(count_q) > MAX_COEFFS) n_act = CntW'(MAX_COEFFS);
  end

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
      for (int i = 0; i < MAX_COEFFS; i++) coef_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegCount) count_q <= cfg_data_i[CntW-1:0];
      for (int i = 0; i < MAX_COEFFS; i++)
        if (cfg_index_i == RegCoef0 + CntW'(i)) coef_q[i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_COEFFS; i++) coefs_o[i*DataW +: DataW] = coef_q[i];
  end

  assign in_stall_o  = (fill_q == 2'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (fill_q != '0);
  assign job_o       = fifo_q[rd_q];

  // queue the accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; fill_q <= '0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (job_take_i) rd_q <= !rd_q;
      fill_q <= fill_q + 2'(push) - 2'(job_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= '{x: point_x_i, g: out_grad_i, last: final_point_i, n: n_act};
  end
endmodule
`default_nettype wire

>>> rtl/peg_back.sv
// ----------------------------------------------------------------------------
// peg_back: runs Horner derivative and power chain on one shared multiplier
// Keeps the coefficient sums and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module peg_back import peg_pkg::*; #(
  parameter int unsigned MAX_COEFFS = MaxCoeffsD,
  parameter int unsigned FRAC_BITS  = FracBitsD
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [MAX_COEFFS*DataW-1:0] coefs_i,
  input  wire logic              job_valid_i,
  input  job_t                   job_i,
  output logic                   job_take_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   result_kind_o,
  output logic [CntW-1:0]        coef_index_o,
  output logic [DataW-1:0]       grad_value_o,
  output logic                   saturated_o,
  output logic                   run_end_o
);
  localparam logic signed [63:0] Hi32 = 64'sd2147483647;
  localparam logic signed [63:0] Lo32 = -64'sd2147483648;
  localparam logic signed [63:0] Hi48 = 64'sh00007FFFFFFFFFFF;
  localparam logic signed [63:0] Lo48 = -64'sh0000800000000000;

  state_e state_q, state_d;
  job_t job_q;
  logic signed [DataW-1:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic hit_q, hit_d;
  logic [CntW-1:0] j_q, j_d, k_q, k_d, e_q, e_d;
  logic signed [SumW-1:0] sum_q [MAX_COEFFS];
  logic signed [DataW-1:0] ma, mb;
  logic signed [63:0] prod, sh, sum_ext, t;
  logic signed [SumW-1:0] sum_new;
  logic sum_we, clr, prod_we;
  logic ov_valid_q, ov_load;
  logic ok_q; logic [CntW-1:0] ok_idx_q; logic [DataW-1:0] ov_val_q; logic ov_sat_q, ov_end_q;
  logic [DataW-1:0] ld_val; logic ld_kind, ld_sat, ld_end; logic [CntW-1:0] ld_idx;
  logic signed [DataW-1:0] coef_j;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v,
                                                   output logic f);
    f = 1'b0;
    if (v > Hi32) begin f = 1'b1; return DataW'(Hi32); end
    if (v < Lo32) begin f = 1'b1; return DataW'(Lo32); end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [SumW-1:0] sat48(input logic signed [63:0] v);
    if (v > Hi48) return SumW'(Hi48);
    if (v < Lo48) return SumW'(Lo48);
    return v[SumW-1:0];
  endfunction

  // shared multiplier, registered
  assign prod = 64'(ma) * 64'(mb);
  assign sh   = prod_q >>> FRAC_BITS;
  assign coef_j = coefs_i[32'(job_q.n - CntW'(1) - j_q)*DataW +: DataW];
  assign out_valid_o = ov_valid_q;
  assign result_kind_o = ok_q; assign coef_index_o = ok_idx_q;
  assign grad_value_o = ov_val_q; assign saturated_o = ov_sat_q; assign run_end_o = ov_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // sequence Horner steps, power chain, sum updates and coefficient results
  always_comb begin
    logic f;
    state_d = state_q; acc_d = acc_q; hit_d = hit_q;
    j_d = j_q; k_d = k_q; e_d = e_q;
    ma = acc_q; mb = job_q.x; prod_we = 1'b0;
    sum_we = 1'b0; clr = 1'b0; sum_new = '0; sum_ext = '0; t = '0;
    job_take_o = 1'b0; ov_load = 1'b0;
    ld_val = '0; ld_kind = KindPoint; ld_sat = 1'b0; ld_end = 1'b0; ld_idx = '0;
    f = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          acc_d = '0; hit_d = 1'b0;
          j_d = job_i.n - CntW'(1);
          state_d = (job_i.n == CntW'(1)) ? S_GMUL : S_HMUL;
        end
      end
      S_HMUL: begin
        prod_we = 1'b1; state_d = S_HADD;
      end
      S_HADD: begin
        t = sh + 64'(coef_j) * 64'(j_q);
        acc_d = sat32(t, f); hit_d = hit_q | f;
        j_d = j_q - CntW'(1);
        state_d = (j_q == CntW'(1)) ? S_GMUL : S_HMUL;
      end
      S_GMUL: begin
        ma = acc_q; mb = job_q.g; prod_we = 1'b1;
        state_d = S_TERM; k_d = '0; e_d = '1;
      end
      S_PMUL: begin
        ma = acc_q; mb = (e_q == '0) ? job_q.g : job_q.x;
        prod_we = 1'b1; state_d = S_TERM;
      end
      S_TERM: begin
        if (e_q == '1) begin
          // point result
          if (!ov_valid_q || !out_stall_i) begin
            ld_val = sat32(sh, f); ld_sat = hit_q | f; ld_end = !job_q.last;
            ov_load = 1'b1;
            acc_d = DataW'(64'sd1 << FRAC_BITS);
            e_d = job_q.n - CntW'(1);
            state_d = S_PMUL;
          end
        end else if (e_q != '0) begin
          acc_d = sat32(sh, f); e_d = e_q - CntW'(1); state_d = S_PMUL;
        end else begin
          sum_ext = 64'(sum_q[k_q]) + 64'(sat48(sh));
          sum_new = sat48(sum_ext); sum_we = 1'b1;
          acc_d = DataW'(64'sd1 << FRAC_BITS);
          if (k_q == job_q.n - CntW'(1)) begin
            k_d = '0;
            state_d = job_q.last ? S_EMIT : S_IDLE;
          end else begin
            k_d = k_q + CntW'(1);
            e_d = job_q.n - CntW'(2) - k_q;
            state_d = S_PMUL;
          end
        end
      end
      S_EMIT: begin
        if (!ov_valid_q || !out_stall_i) begin
          ld_val = sat32(64'(sum_q[k_q]), f); ld_sat = f; ld_kind = KindCoef; ld_idx = k_q;
          ld_end = (k_q == job_q.n - CntW'(1)); ov_load = 1'b1;
          k_d = k_q + CntW'(1);
          if (ld_end) begin clr = 1'b1; state_d = S_IDLE; end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_valid_q <= 1'b0;
      for (int i = 0; i < MAX_COEFFS; i++) sum_q[i] <= '0;
    end else begin
      if (ov_load) ov_valid_q <= 1'b1;
      else if (!out_stall_i) ov_valid_q <= 1'b0;
      if (clr) for (int i = 0; i < MAX_COEFFS; i++) sum_q[i] <= '0;
      else if (sum_we) sum_q[k_q] <= sum_new;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (job_take_o) job_q <= job_i;
    acc_q <= acc_d; hit_q <= hit_d; j_q <= j_d; k_q <= k_d; e_q <= e_d;
    if (prod_we) prod_q <= prod;
    if (ov_load) begin
      ok_q <= ld_kind; ok_idx_q <= ld_idx; ov_val_q <= ld_val;
      ov_sat_q <= ld_sat; ov_end_q <= ld_end;
    end
  end
endmodule
`default_nettype wire

>>> rtl/polynomial_eval_gradient.sv
// ----------------------------------------------------------------------------
// polynomial_eval_gradient: backward pass of Q16.16 polynomial evaluation
//
//   channel | signals                                      | transfer when
//   in      | in_valid_i, in_stall_o, point_x_i..final     | valid & !stall
//   out     | out_valid_o, out_stall_i, result_kind_o..end | valid & !stall
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i            | we
//
// One shared 32x32 multiplier sets the rate: the sequencer takes a new item
// only from idle, once done with the current one, and on a last item it
// also emits the sums. A two-entry queue parts input from the sequencer;
// the output register holds a result under stall while the sequencer waits.
// Reset empties the queue, clears coefficients and sums, sets the count to 1.
// ----------------------------------------------------------------------------
`default_nettype none
module polynomial_eval_gradient import peg_pkg::*; #(
  parameter int unsigned MAX_COEFFS = MaxCoeffsD,
  parameter int unsigned FRAC_BITS  = FracBitsD
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CntW-1:0]  cfg_index_i,
  input  wire logic [DataW-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [DataW-1:0] point_x_i,
  input  wire logic [DataW-1:0] out_grad_i,
  input  wire logic             final_point_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  result_kind_o,
  output logic [CntW-1:0]       coef_index_o,
  output logic [DataW-1:0]      grad_value_o,
  output logic                  saturated_o,
  output logic                  run_end_o
);
  logic [MAX_COEFFS*DataW-1:0] coefs;
  logic job_valid, job_take;
  job_t job;

  peg_front #(.MAX_COEFFS(MAX_COEFFS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .point_x_i, .out_grad_i, .final_point_i,
    .coefs_o(coefs), .job_valid_o(job_valid), .job_o(job), .job_take_i(job_take)
  );

  peg_back #(.MAX_COEFFS(MAX_COEFFS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .coefs_i(coefs), .job_valid_i(job_valid), .job_i(job),
    .job_take_o(job_take), .out_valid_o, .out_stall_i, .result_kind_o,
    .coef_index_o, .grad_value_o, .saturated_o, .run_end_o
  );
endmodule
`default_nettype wire
